/* hdl/ktr_pkg.sv */
package ktr_pkg;

    // Operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Kinds above this value share the last tally
    localparam logic [31:0] KIND_CLAMP = 32'd3;

    localparam int TALLY_N = 4;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [31:0] payload;
        logic [31:0] kind;
    } req_item_t;

    typedef struct packed {
        logic        hit;
        logic        full_res;
        logic [6:0]  entry_count;
        logic [31:0] tally_zero;
        logic [31:0] tally_one;
        logic [31:0] tally_two;
        logic [31:0] tally_rest;
    } rsp_item_t;

    // One stored record; the kind is kept already clamped to a tally index
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] payload;
        logic [1:0]  kind_sel;
    } record_t;

endpackage

/* hdl/ktr_store.sv */
module ktr_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  ktr_pkg::record_t   wr_data,
    input  logic [IDX_W-1:0]   rd_addr,
    output ktr_pkg::record_t   rd_data
);
    import ktr_pkg::*;

    record_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/keyed_table_remove_with_tally.sv */
// Packed table of up to CAPACITY records (key, payload, kind) with four
// wrapping removal tallies. An append item writes after the last record, or
// reports full_res when the table is full. A remove item scans from the front
// for the first matching key, bumps the tally picked by that record's kind
// (kinds of 3 and above share tally_rest), and moves every later record down
// one place. The records sit in one single-port-read, single-port-write
// memory, and the sequencer moves one record per cycle through its read
// port; a remove walks every stored record whether it hits or misses.
// req_stall is high from accept until the result has been loaded into the
// output register; one finished result may wait on rsp_stall while the
// next item is already accepted.
module keyed_table_remove_with_tally #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ktr_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ktr_pkg::rsp_item_t  rsp
);
    import ktr_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [31:0]        key_reg, key_next;
    logic               hit_reg, hit_next;
    logic               full_reg, full_next;
    logic [31:0]        tally_reg [TALLY_N];
    logic [31:0]        tally_next [TALLY_N];
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg, rsp_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    record_t            wr_data;
    logic [IDX_W-1:0]   rd_addr;
    record_t            rd_data;

    logic               req_fire;
    logic               slot_free;
    logic [CNT_W-1:0]   ptr_inc;
    logic [CNT_W-1:0]   ptr_dec;
    logic               last_entry;
    logic [1:0]         kind_sel_in;

    ktr_store #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    assign last_entry = (ptr_inc == count_reg);
    assign kind_sel_in = (req.kind > KIND_CLAMP) ? 2'(KIND_CLAMP) : req.kind[1:0];

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer and memory port control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        full_next      = full_reg;
        tally_next     = tally_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = '{key: req.key, payload: req.payload, kind_sel: kind_sel_in};
        rd_addr = '0;

        // Output register drains independently
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    key_next  = req.key;
                    hit_next  = 1'b0;
                    full_next = 1'b0;
                    ptr_next  = '0;
                    if (req.op == OP_APPEND)
                    begin
                        state_next = S_EMIT;
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            hit_next   = 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // first record read is issued now
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // rd_data holds the record at ptr_reg
                if (rd_data.key == key_reg)
                begin
                    hit_next = 1'b1;
                    tally_next[rd_data.kind_sel] = tally_reg[rd_data.kind_sel] + 32'd1;
                    if (last_entry)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        rd_addr    = ptr_inc[IDX_W-1:0];
                        ptr_next   = ptr_inc;
                        state_next = S_SHIFT;
                    end
                end
                else if (last_entry)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr  = ptr_inc[IDX_W-1:0];
                    ptr_next = ptr_inc;
                end
            end

            S_SHIFT:
            begin
                // move the record at ptr_reg down one place
                wr_en   = 1'b1;
                wr_addr = ptr_dec[IDX_W-1:0];
                wr_data = rd_data;
                if (last_entry)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr  = ptr_inc[IDX_W-1:0];
                    ptr_next = ptr_inc;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.hit         = hit_reg;
                    rsp_next.full_res    = full_reg;
                    rsp_next.entry_count = 7'(count_reg);
                    rsp_next.tally_zero  = tally_reg[0];
                    rsp_next.tally_one   = tally_reg[1];
                    rsp_next.tally_two   = tally_reg[2];
                    rsp_next.tally_rest  = tally_reg[3];
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            key_reg       <= '0;
            hit_reg       <= 1'b0;
            full_reg      <= 1'b0;
            for (int i = 0; i < TALLY_N; i++)
            begin
                tally_reg[i] <= '0;
            end
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            key_reg       <= key_next;
            hit_reg       <= hit_next;
            full_reg      <= full_next;
            tally_reg     <= tally_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule
